### design/atoi_pkg.sv
// ----------------------------------------------------------------------------
// atoi_pkg: shared types and constants of the ASCII to integer parser
// Holds the request structs, the parser control struct, the phase codes,
// the character codes and the digit decode function.
// ----------------------------------------------------------------------------
`default_nettype none

package atoi_pkg;

  // Default sizes of the parser.
  localparam int DEF_VALUE_BITS = 64;
  localparam int DEF_MAX_LEN    = 256;

  // Parse phase codes.
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LEAD   = 3'd1;
  localparam logic [2:0] PH_SIGNED = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_HEXPFX = 3'd4;
  localparam logic [2:0] PH_DIGITS = 3'd5;

  // Character codes.
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_PLUS    = 8'd43;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CH_DIG0    = 8'd48;
  localparam logic [7:0] CH_DIG9    = 8'd57;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_X = 8'd88;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_X = 8'd120;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] UPPER_BIAS = 8'd55;   // 'A' - 10
  localparam logic [7:0] LOWER_BIAS = 8'd87;   // 'a' - 10

  // Radix codes.
  localparam logic [5:0] RADIX_AUTO = 6'd0;
  localparam logic [5:0] RADIX_MIN  = 6'd2;
  localparam logic [5:0] RADIX_OCT  = 6'd8;
  localparam logic [5:0] RADIX_DEC  = 6'd10;
  localparam logic [5:0] RADIX_HEX  = 6'd16;
  localparam logic [5:0] RADIX_MAX  = 6'd36;
  localparam logic [5:0] NO_DIGIT   = 6'd63;

  // Input request: one byte of a string.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       string_start;
  } atoi_in_t;

  // Result request: one converted number.
  typedef struct packed {
    logic signed [63:0] parsed_value;
    logic               range_error;
    logic [8:0]         end_offset;
  } atoi_out_t;

  // Parser control state.
  typedef struct packed {
    logic [2:0] phase;
    logic       neg;
    logic       seen;
    logic       ovf;
    logic [5:0] radix;
  } atoi_ctrl_t;

  // Value of a digit or letter, NO_DIGIT for any other byte.
  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'(NO_DIGIT);
    if (c >= CH_DIG0 && c <= CH_DIG9) begin
      d = c - CH_DIG0;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d = c - UPPER_BIAS;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d = c - LOWER_BIAS;
    end
    return d[5:0];
  endfunction

endpackage

`default_nettype wire

### design/atoi_step.sv
// ----------------------------------------------------------------------------
// atoi_step: one parser step
// Takes the registered byte and the parser state, and gives the next state
// and, when the byte ends the number, the converted result.
// ----------------------------------------------------------------------------
`default_nettype none

module atoi_step import atoi_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int MAX_LEN    = DEF_MAX_LEN,
  parameter int POS_W      = $clog2(MAX_LEN + 1)
) (
  input  atoi_in_t                in_item,
  input  logic [5:0]              number_base,
  input  atoi_ctrl_t              ctrl_q,
  input  logic [VALUE_BITS-1:0]   acc_q,
  input  logic [POS_W-1:0]        pos_q,
  output atoi_ctrl_t              ctrl_d,
  output logic [VALUE_BITS-1:0]   acc_d,
  output logic [POS_W-1:0]        pos_d,
  output logic                    emit,
  output atoi_out_t               result
);

  localparam int SUM_W = VALUE_BITS + 7;

  localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

  atoi_ctrl_t            cur;
  logic [VALUE_BITS-1:0] cur_acc;
  logic [POS_W-1:0]      cur_pos;
  logic [7:0]            c;
  logic [5:0]            dv;
  logic                  is_ws;
  logic                  first;
  logic                  take;
  logic [5:0]            tr;
  logic [VALUE_BITS-1:0] limit;
  logic [SUM_W-1:0]      sum;
  logic [POS_W-1:0]      end_pos;
  logic [POS_W+8:0]      end_wide;
  logic [VALUE_BITS-1:0] val;

  always_comb begin
    // A start mark reloads the state before the byte is looked at.
    if (in_item.string_start) begin
      cur.phase = PH_LEAD;
      cur.neg   = 1'b0;
      cur.seen  = 1'b0;
      cur.ovf   = 1'b0;
      cur.radix = number_base;
      cur_acc   = '0;
      cur_pos   = '0;
    end else begin
      cur     = ctrl_q;
      cur_acc = acc_q;
      cur_pos = pos_q;
    end

    c     = in_item.char_byte;
    dv    = digit_value(c);
    is_ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);

    ctrl_d  = cur;
    acc_d   = cur_acc;
    emit    = 1'b0;
    end_pos = cur_pos;
    first   = 1'b0;
    take    = 1'b0;
    tr      = cur.radix;

    // Phase decode.
    unique case (cur.phase)
      PH_IDLE: begin
      end
      PH_LEAD: begin
        if (is_ws) begin
        end else if (c == CH_MINUS) begin
          ctrl_d.neg   = 1'b1;
          ctrl_d.phase = PH_SIGNED;
        end else if (c == CH_PLUS) begin
          ctrl_d.phase = PH_SIGNED;
        end else begin
          first = 1'b1;
        end
      end
      PH_SIGNED: begin
        first = 1'b1;
      end
      PH_ZERO: begin
        if (c == CH_LOWER_X || c == CH_UPPER_X) begin
          ctrl_d.radix = RADIX_HEX;
          ctrl_d.phase = PH_HEXPFX;
        end else begin
          take = 1'b1;
          tr   = (cur.radix == RADIX_AUTO) ? RADIX_OCT : cur.radix;
        end
      end
      PH_HEXPFX: begin
        if (dv < RADIX_HEX) begin
          take = 1'b1;
        end else begin
          // A lone zero before the x is the whole number.
          emit         = 1'b1;
          ctrl_d.phase = PH_IDLE;
          end_pos      = (cur_pos != '0) ? cur_pos - POS_W'(1) : '0;
        end
      end
      PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
      end
    endcase

    // First character after white space or sign.
    if (first) begin
      if (c == CH_DIG0 && (cur.radix == RADIX_AUTO || cur.radix == RADIX_HEX)) begin
        ctrl_d.seen  = 1'b1;
        acc_d        = '0;
        ctrl_d.phase = PH_ZERO;
      end else begin
        take = 1'b1;
        tr   = (cur.radix == RADIX_AUTO) ? RADIX_DEC : cur.radix;
      end
    end

    // Multiply-add with overflow check against the signed limit.
    limit = VAL_MAX + VALUE_BITS'(cur.neg);
    sum   = SUM_W'(cur_acc) * SUM_W'(tr) + SUM_W'(dv);

    if (take) begin
      ctrl_d.phase = PH_DIGITS;
      ctrl_d.radix = tr;
      if (tr < RADIX_MIN || tr > RADIX_MAX || dv >= tr) begin
        emit         = 1'b1;
        ctrl_d.phase = PH_IDLE;
        end_pos      = cur_pos;
      end else begin
        ctrl_d.seen = 1'b1;
        if (!cur.ovf) begin
          if (sum > SUM_W'(limit)) begin
            ctrl_d.ovf = 1'b1;
          end else begin
            acc_d = sum[VALUE_BITS-1:0];
          end
        end
      end
    end

    // Byte index, held at its maximum.
    pos_d = cur_pos;
    if (cur.phase != PH_IDLE && cur_pos < POS_W'(MAX_LEN)) begin
      pos_d = cur_pos + POS_W'(1);
    end

    // Result value, saturated on overflow and sign-extended.
    if (cur.ovf) begin
      val = cur.neg ? VAL_MIN : VAL_MAX;
    end else begin
      val = cur.neg ? VALUE_BITS'(~cur_acc + VALUE_BITS'(1)) : cur_acc;
    end
    end_wide            = (POS_W + 9)'(end_pos);
    result.parsed_value = 64'($signed(val));
    result.range_error  = cur.ovf;
    result.end_offset   = cur.seen ? end_wide[8:0] : 9'd0;
  end

endmodule

`default_nettype wire

### design/ascii_to_signed_integer_parser_unit.sv
// ----------------------------------------------------------------------------
// ascii_to_signed_integer_parser_unit: streaming string to integer converter
// Converts a string, one byte per request, into a signed integer with
// white space skipping, sign, radix prefix and saturation on overflow.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                               | Moves
//   --------+-------------------------------------+-------------------------
//   in      | in_valid, in_stall, in_item         | one string byte
//   out     | out_valid, out_stall, out_item      | one converted number
//   cfg     | cfg_wr_en, cfg_wr_data              | number base register
//
// One byte is taken every cycle while in_stall is low. A byte is first
// captured in the input register, then one multiply-add step updates the
// parser and, when the byte ends a number, loads the result register.
// Reset clears the handshake and parser control; the number base returns
// to ten. A stalled result holds; one more byte waits in the input register
// and then in_stall rises until the result is taken.
//
`default_nettype none

module ascii_to_signed_integer_parser_unit import atoi_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int MAX_LEN    = DEF_MAX_LEN
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  atoi_in_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output atoi_out_t  out_item,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data
);

  localparam int POS_W = $clog2(MAX_LEN + 1);

  logic                  in_vld_r;
  logic                  in_vld_nxt;
  atoi_in_t              in_item_r;
  logic                  out_vld_r;
  logic                  out_vld_nxt;
  atoi_out_t             out_item_r;
  logic [5:0]            number_base_r;
  atoi_ctrl_t            ctrl_r;
  atoi_ctrl_t            ctrl_nxt;
  logic [VALUE_BITS-1:0] acc_r;
  logic [VALUE_BITS-1:0] acc_nxt;
  logic [POS_W-1:0]      pos_r;
  logic [POS_W-1:0]      pos_nxt;
  logic                  emit;
  atoi_out_t             result;
  logic                  adv;
  logic                  proc;

  // Pipeline flow: the step runs when the result register can take a result.
  assign adv         = !out_vld_r || !out_stall;
  assign proc        = in_vld_r && adv;
  assign in_stall    = in_vld_r && !adv;
  assign in_vld_nxt  = in_valid || in_stall;
  assign out_vld_nxt = adv ? (proc && emit) : 1'b1;

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  // Parser step.
  atoi_step #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_LEN    (MAX_LEN),
    .POS_W      (POS_W)
  ) u_step (
    .in_item     (in_item_r),
    .number_base (number_base_r),
    .ctrl_q      (ctrl_r),
    .acc_q       (acc_r),
    .pos_q       (pos_r),
    .ctrl_d      (ctrl_nxt),
    .acc_d       (acc_nxt),
    .pos_d       (pos_nxt),
    .emit        (emit),
    .result      (result)
  );

  // Handshake and parser control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      number_base_r <= RADIX_DEC;
      ctrl_r.phase  <= PH_IDLE;
      ctrl_r.neg    <= 1'b0;
      ctrl_r.seen   <= 1'b0;
      ctrl_r.ovf    <= 1'b0;
      ctrl_r.radix  <= RADIX_DEC;
      acc_r         <= '0;
      pos_r         <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        number_base_r <= cfg_wr_data;
      end
      if (proc) begin
        ctrl_r <= ctrl_nxt;
        acc_r  <= acc_nxt;
        pos_r  <= pos_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
    if (proc && emit) begin
      out_item_r <= result;
    end
  end

endmodule

`default_nettype wire

### design/atoi_checker.sv
// ----------------------------------------------------------------------------
// atoi_checker: port checks of the parser
// Watches the top level's ports and flags handshake and flow errors.
// ----------------------------------------------------------------------------
`default_nettype none

module atoi_checker import atoi_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire atoi_in_t   in_item,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire atoi_out_t  out_item
);

  // A stalled result stays and does not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // A stalled byte request stays and does not change.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("byte request changed while stalled");

  // The input only backs up behind a stalled result.
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // A new result comes from a byte taken at the port and stepped from the input register.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching input byte");

endmodule

bind ascii_to_signed_integer_parser_unit atoi_checker u_atoi_checker (.*);

`default_nettype wire
